// ===== hdl/tpmq_pkg.sv =====
// Package for the tree path max edge query block.
// Holds payload structs, operation codes, queue entry and engine state types.
// No dependencies.
package tpmq_pkg;

  localparam int NodesDefault      = 1024;
  localparam int LevelsDefault     = 10;
  localparam int WeightBitsDefault = 32;
  localparam int CostBits          = 48;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_MST_TOTAL  = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic [31:0] edge_weight;
    logic [9:0]  node_depth;
  } in_item_t;

  typedef struct packed {
    logic [31:0] path_max;
    logic [47:0] replace_cost;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    op_t         op;
    logic        a_ok;
    logic        b_ok;
    logic [9:0]  node_a;
    logic [9:0]  node_b;
    logic [31:0] weight;
    logic [9:0]  depth;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEP_RD,
    ST_DEP_WT,
    ST_LIFT_RD,
    ST_LIFT_WT,
    ST_DOWN_RD,
    ST_DOWN_WT,
    ST_LAST_RD,
    ST_LAST_WT,
    ST_COST,
    ST_BLD_RD1,
    ST_BLD_WT1,
    ST_BLD_RD2,
    ST_BLD_WT2,
    ST_BLD_WR
  } st_t;

endpackage

// ===== hdl/tpmq_front.sv =====
// Front part: accepts items, classifies them, and queues them for the engine.
// Depends on tpmq_pkg.
module tpmq_front #(
  parameter int NODES = tpmq_pkg::NodesDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tpmq_pkg::in_item_t in_item,
  output logic              q_valid,
  output tpmq_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);
  localparam int Depth = 2;

  tpmq_pkg::cmd_t q_r [Depth];
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wr_ptr_r, rd_ptr_r;
  tpmq_pkg::cmd_t cmd;
  logic           push;

  // Classify: range check of node indexes
  always_comb begin
    cmd.op     = tpmq_pkg::op_t'(in_item.operation);
    cmd.a_ok   = (32'(in_item.node_a) < NODES);
    cmd.b_ok   = (32'(in_item.node_b) < NODES);
    cmd.node_a = in_item.node_a;
    cmd.node_b = in_item.node_b;
    cmd.weight = in_item.edge_weight;
    cmd.depth  = in_item.node_depth;
  end

  assign busy    = (cnt_r == 2'(Depth));
  assign push    = start && !busy && (cmd.op != tpmq_pkg::OP_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop && q_valid) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= cmd;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(Depth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(Depth)) |-> busy) else $error("full but not busy");
`endif
endmodule

// ===== hdl/tpmq_engine.sv =====
// Back part: lifting tables, build sweep, and path query walk.
// Depends on tpmq_pkg.
module tpmq_engine #(
  parameter int NODES       = tpmq_pkg::NodesDefault,
  parameter int LEVELS      = tpmq_pkg::LevelsDefault,
  parameter int WEIGHT_BITS = tpmq_pkg::WeightBitsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  tpmq_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  input  logic [9:0]          node_count,
  input  logic [47:0]         mst_total,
  output logic                out_valid,
  output tpmq_pkg::out_item_t out_item
);
  localparam int NB    = $clog2(NODES);
  localparam int LB    = $clog2(LEVELS);
  localparam int Words = NODES * LEVELS;
  localparam int AB    = $clog2(Words);
  localparam int WB    = WEIGHT_BITS;
  // depth difference wide enough to index every level
  localparam int DB    = (LEVELS > 10) ? LEVELS : 10;

  // Ancestor and path max stored together, one row entry per (node, level)
  logic [NB+WB-1:0] tab_mem [Words];
  logic [9:0]       dep_mem [NODES];

  logic [AB-1:0]    ra_u, ra_v, wa;
  logic             we;
  logic [NB+WB-1:0] wd;
  logic [NB+WB-1:0] rd_u_r, rd_v_r;
  logic [NB-1:0]    da_u, da_v;
  logic             dwe;
  logic [9:0]       dd_u_r, dd_v_r;

  tpmq_pkg::st_t st_r, st_nxt;
  tpmq_pkg::cmd_t cmd_r, cmd_nxt;
  logic [NB-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [NB-1:0] node_r, node_nxt;
  logic [LB-1:0] lvl_r, lvl_nxt;
  logic [DB-1:0] diff_r, diff_nxt;
  logic [WB-1:0] best_r, best_nxt, half_r, half_nxt;
  logic          ovalid_nxt;
  tpmq_pkg::out_item_t oitem_nxt;
  logic [NB-1:0] top;
  logic [NB-1:0] a_idx, b_idx;
  logic [48:0]   sum;
  logic [WB-1:0] pm_u, pm_v;
  logic [NB-1:0] an_u, an_v;

  function automatic logic [AB-1:0] addr(input logic [NB-1:0] n, input logic [LB-1:0] l);
    logic [AB+NB-1:0] p;
    p = (AB+NB)'(n) * (AB+NB)'(LEVELS) + (AB+NB)'(l);
    return p[AB-1:0];
  endfunction

  function automatic logic [WB-1:0] wmax(input logic [WB-1:0] a, input logic [WB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Memories: one write port, two registered read ports; node 0 reads zero
  always_ff @(posedge clk) begin
    if (we) tab_mem[wa] <= wd;
    rd_u_r <= tab_mem[ra_u];
    rd_v_r <= tab_mem[ra_v];
  end
  always_ff @(posedge clk) begin
    if (dwe) dep_mem[node_r] <= cmd_r.depth;
    dd_u_r <= dep_mem[da_u];
    dd_v_r <= dep_mem[da_v];
  end

  assign an_u = (u_r == '0) ? '0 : rd_u_r[NB+WB-1:WB];
  assign pm_u = (u_r == '0) ? '0 : rd_u_r[WB-1:0];
  assign an_v = (v_r == '0) ? '0 : rd_v_r[NB+WB-1:WB];
  assign pm_v = (v_r == '0) ? '0 : rd_v_r[WB-1:0];

  assign top   = (32'(node_count) > NODES - 1) ? NB'(NODES - 1) : NB'(node_count);
  assign a_idx = q_cmd.a_ok ? NB'(q_cmd.node_a) : '0;
  assign b_idx = q_cmd.b_ok ? NB'(q_cmd.node_b) : '0;
  assign sum   = 49'(mst_total) + 49'(cmd_r.weight);

  // Sequencer
  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; u_nxt = u_r; v_nxt = v_r; node_nxt = node_r;
    lvl_nxt = lvl_r; diff_nxt = diff_r; best_nxt = best_r; half_nxt = half_r;
    q_pop = 1'b0; we = 1'b0; dwe = 1'b0; wa = '0; wd = '0;
    ra_u = addr(u_r, lvl_r); ra_v = addr(v_r, lvl_r);
    da_u = u_r; da_v = v_r;
    ovalid_nxt = 1'b0; oitem_nxt = '0;
    case (st_r)
      tpmq_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            tpmq_pkg::OP_LOAD: begin
              // Level 0 write and depth store
              if (q_cmd.a_ok && q_cmd.node_a != '0) begin
                we = 1'b1;
                wa = addr(NB'(q_cmd.node_a), '0);
                wd = {b_idx, WB'(q_cmd.weight)};
                node_nxt = NB'(q_cmd.node_a);
                st_nxt = tpmq_pkg::ST_BLD_WR;
              end
            end
            tpmq_pkg::OP_BUILD: begin
              if (node_count != '0 && LEVELS > 1) begin
                lvl_nxt = LB'(1); node_nxt = NB'(1); u_nxt = NB'(1);
                st_nxt = tpmq_pkg::ST_BLD_RD1;
              end
            end
            tpmq_pkg::OP_QUERY: begin
              u_nxt = a_idx; v_nxt = b_idx; best_nxt = '0;
              st_nxt = tpmq_pkg::ST_DEP_RD;
            end
            default: ;
          endcase
        end
      end
      tpmq_pkg::ST_BLD_WR: begin
        // depth write slot after a load
        dwe = 1'b1;
        st_nxt = tpmq_pkg::ST_IDLE;
      end
      tpmq_pkg::ST_DEP_RD: st_nxt = tpmq_pkg::ST_DEP_WT;
      tpmq_pkg::ST_DEP_WT: begin
        // Make v the deeper endpoint
        if (((u_r == '0) ? 10'd0 : dd_u_r) > ((v_r == '0) ? 10'd0 : dd_v_r)) begin
          u_nxt = v_r; v_nxt = u_r;
          diff_nxt = DB'(dd_u_r - ((v_r == '0) ? 10'd0 : dd_v_r));
        end else begin
          diff_nxt = DB'(((v_r == '0) ? 10'd0 : dd_v_r) - ((u_r == '0) ? 10'd0 : dd_u_r));
        end
        lvl_nxt = '0;
        st_nxt = tpmq_pkg::ST_LIFT_RD;
      end
      tpmq_pkg::ST_LIFT_RD: begin
        if (diff_r[lvl_r]) st_nxt = tpmq_pkg::ST_LIFT_WT;
        else if (32'(lvl_r) == LEVELS - 1) begin
          lvl_nxt = LB'(LEVELS - 1); st_nxt = tpmq_pkg::ST_DOWN_RD;
        end else lvl_nxt = lvl_r + LB'(1);
      end
      tpmq_pkg::ST_LIFT_WT: begin
        best_nxt = wmax(best_r, pm_v);
        v_nxt = an_v;
        if (32'(lvl_r) == LEVELS - 1) begin
          lvl_nxt = LB'(LEVELS - 1); st_nxt = tpmq_pkg::ST_DOWN_RD;
        end else begin
          lvl_nxt = lvl_r + LB'(1); st_nxt = tpmq_pkg::ST_LIFT_RD;
        end
      end
      tpmq_pkg::ST_DOWN_RD: begin
        if (u_r == v_r) st_nxt = tpmq_pkg::ST_COST;
        else st_nxt = tpmq_pkg::ST_DOWN_WT;
      end
      tpmq_pkg::ST_DOWN_WT: begin
        if (an_u != an_v) begin
          best_nxt = wmax(best_r, wmax(pm_u, pm_v));
          u_nxt = an_u; v_nxt = an_v;
        end
        if (lvl_r == '0) st_nxt = tpmq_pkg::ST_LAST_RD;
        else begin
          lvl_nxt = lvl_r - LB'(1); st_nxt = tpmq_pkg::ST_DOWN_WT;
          ra_u = addr(u_nxt, lvl_nxt); ra_v = addr(v_nxt, lvl_nxt);
          st_nxt = tpmq_pkg::ST_LAST_WT;
        end
      end
      tpmq_pkg::ST_LAST_WT: begin
        // read issued for lower level, now compare there
        st_nxt = tpmq_pkg::ST_DOWN_WT;
      end
      tpmq_pkg::ST_LAST_RD: begin
        ra_u = addr(u_r, '0); ra_v = addr(v_r, '0);
        st_nxt = tpmq_pkg::ST_COST;
        best_nxt = best_r;
        half_nxt = '1;
      end
      tpmq_pkg::ST_COST: begin
        logic [WB-1:0] b;
        b = (half_r != '0) ? wmax(best_r, wmax(pm_u, pm_v)) : best_r;
        half_nxt = '0;
        oitem_nxt.path_max = 32'(b);
        if (sum < 49'(b)) oitem_nxt.replace_cost = '0;
        else if ((sum - 49'(b)) > 49'({48{1'b1}})) oitem_nxt.replace_cost = '1;
        else oitem_nxt.replace_cost = 48'(sum - 49'(b));
        ovalid_nxt = 1'b1;
        st_nxt = tpmq_pkg::ST_IDLE;
      end
      tpmq_pkg::ST_BLD_RD1: begin
        ra_u = addr(node_r, lvl_r - LB'(1));
        st_nxt = tpmq_pkg::ST_BLD_WT1;
      end
      tpmq_pkg::ST_BLD_WT1: begin
        // node is never 0 here, so read raw
        half_nxt = rd_u_r[WB-1:0];
        ra_v = addr(rd_u_r[NB+WB-1:WB], lvl_r - LB'(1));
        v_nxt = rd_u_r[NB+WB-1:WB];
        st_nxt = tpmq_pkg::ST_BLD_RD2;
      end
      tpmq_pkg::ST_BLD_RD2: begin
        // keep the midpoint read on the lower level
        ra_v = addr(v_r, lvl_r - LB'(1));
        st_nxt = tpmq_pkg::ST_BLD_WT2;
      end
      tpmq_pkg::ST_BLD_WT2: begin
        we = 1'b1;
        wa = addr(node_r, lvl_r);
        wd = {an_v, wmax(half_r, pm_v)};
        half_nxt = '0;
        if (node_r >= top) begin
          node_nxt = NB'(1);
          if (32'(lvl_r) == LEVELS - 1) st_nxt = tpmq_pkg::ST_IDLE;
          else begin
            lvl_nxt = lvl_r + LB'(1); st_nxt = tpmq_pkg::ST_BLD_RD1;
          end
        end else begin
          node_nxt = node_r + NB'(1); st_nxt = tpmq_pkg::ST_BLD_RD1;
        end
      end
      default: st_nxt = tpmq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= tpmq_pkg::ST_IDLE;
      out_valid <= 1'b0;
      half_r    <= '0;
    end else begin
      st_r      <= st_nxt;
      out_valid <= ovalid_nxt;
      half_r    <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; u_r <= u_nxt; v_r <= v_nxt; node_r <= node_nxt;
    lvl_r <= lvl_nxt; diff_r <= diff_nxt; best_r <= best_nxt;
    out_item <= oitem_nxt;
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (st_r == tpmq_pkg::ST_IDLE)) else $error("pop while busy");
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result held two cycles");
  a_out_from_cost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(st_r == tpmq_pkg::ST_COST)) else $error("stray result");
`endif
endmodule

// ===== hdl/tree_path_max_edge_query.sv =====
// Top level of the tree path max edge query block.
// Instantiates tpmq_front and tpmq_engine; uses tpmq_pkg.
//
// Channel   Ports                         Transfer
// input     start / busy / in_item        start && !busy
// result    out_valid / out_item          strobe, one cycle
// config    cfg_we / cfg_idx / cfg_data   cfg_we, immediate
//
// A load writes its table entry and then its depth; a query makes a lift pass and a
// descent pass over the levels; a build makes two dependent reads per table entry.
// A result strobes in the cycle after the query's cost state.
// A two-entry queue lets two items be taken while the engine works.
// Reset is synchronous; tables are undefined until loaded, node 0 reads zero.
// The receiver cannot stall results.
module tree_path_max_edge_query #(
  parameter int NODES       = tpmq_pkg::NodesDefault,
  parameter int LEVELS      = tpmq_pkg::LevelsDefault,
  parameter int WEIGHT_BITS = tpmq_pkg::WeightBitsDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tpmq_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tpmq_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [47:0]         cfg_data
);
  logic           q_valid, q_pop;
  tpmq_pkg::cmd_t q_cmd;
  logic [9:0]     node_count_r;
  logic [47:0]    mst_total_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 10'd1;
      mst_total_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_idx == tpmq_pkg::CFG_NODE_COUNT) node_count_r <= cfg_data[9:0];
      else if (cfg_idx == tpmq_pkg::CFG_MST_TOTAL) mst_total_r <= cfg_data;
    end
  end

  tpmq_front #(.NODES(NODES)) u_front (
    .clk, .rst_n, .start, .busy, .in_item,
    .q_valid, .q_cmd, .q_pop
  );

  tpmq_engine #(.NODES(NODES), .LEVELS(LEVELS), .WEIGHT_BITS(WEIGHT_BITS)) u_engine (
    .clk, .rst_n, .q_valid, .q_cmd, .q_pop,
    .node_count(node_count_r), .mst_total(mst_total_r),
    .out_valid, .out_item
  );
endmodule

// ===== sim/tree_path_max_edge_query_tb.sv =====
// Testbench for tree_path_max_edge_query: loads trees, builds lifting tables, checks
// path-max and replace-cost results against an in-bench predictor. Depends on tpmq_pkg.
module tree_path_max_edge_query_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumNodes   = 1024;
  localparam int NumLevels  = 10;
  localparam int CycleLimit = 1500000;
  localparam logic [47:0] CostMax = 48'hFFFF_FFFF_FFFF;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  tpmq_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  tpmq_pkg::out_item_t out_item;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_idx = '0;
  logic [47:0]         cfg_data = '0;

  tree_path_max_edge_query uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state: lifting tables, depths, registers
  logic [9:0]  lift_anc [NumNodes][NumLevels];
  logic [31:0] lift_max [NumNodes][NumLevels];
  logic [9:0]  node_dep [NumNodes];
  logic [9:0]  cur_count;
  logic [47:0] cur_total;

  tpmq_pkg::in_item_t  pending_items[$];
  tpmq_pkg::out_item_t expected_paths[$];
  int        mismatches = 0;
  int        cycles = 0;
  logic [9:0] tree_dep [NumNodes];

  function automatic logic [31:0] max32(logic [31:0] x, logic [31:0] y);
    return (x > y) ? x : y;
  endfunction

  function automatic void build_lifting();
    int top;
    logic [9:0] mid;
    top = int'(cur_count);
    for (int j = 1; j < NumLevels; j++) begin
      for (int u = 1; u <= top; u++) begin
        mid = lift_anc[u][j-1];
        lift_anc[u][j] = lift_anc[mid][j-1];
        lift_max[u][j] = max32(lift_max[u][j-1], lift_max[mid][j-1]);
      end
    end
  endfunction

  function automatic logic [31:0] heaviest_on_path(logic [9:0] a, logic [9:0] b);
    logic [31:0] best;
    logic [9:0]  u, v, t, diff, pu, pv;
    best = '0;
    u = a;
    v = b;
    if (node_dep[u] > node_dep[v]) begin
      t = u; u = v; v = t;
    end
    diff = node_dep[v] - node_dep[u];
    for (int i = 0; i < NumLevels; i++) begin
      if (diff[i]) begin
        best = max32(best, lift_max[v][i]);
        v = lift_anc[v][i];
      end
    end
    if (u == v) return best;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      pu = lift_anc[u][i];
      pv = lift_anc[v][i];
      if (pu != pv) begin
        best = max32(best, max32(lift_max[u][i], lift_max[v][i]));
        u = pu;
        v = pv;
      end
    end
    return max32(best, max32(lift_max[u][0], lift_max[v][0]));
  endfunction

  // Apply one accepted item to the predictor
  function automatic void predict_item(tpmq_pkg::in_item_t it);
    tpmq_pkg::out_item_t r;
    logic [48:0]         sum;
    case (tpmq_pkg::op_t'(it.operation))
      tpmq_pkg::OP_LOAD: begin
        if (it.node_a != 0) begin
          lift_anc[it.node_a][0] = it.node_b;
          lift_max[it.node_a][0] = it.edge_weight;
          node_dep[it.node_a] = it.node_depth;
        end
      end
      tpmq_pkg::OP_BUILD: build_lifting();
      tpmq_pkg::OP_QUERY: begin
        r.path_max = heaviest_on_path(it.node_a, it.node_b);
        sum = {1'b0, cur_total} + 49'(it.edge_weight);
        if (sum < {17'd0, r.path_max}) r.replace_cost = '0;
        else if (sum - 49'(r.path_max) > {1'b0, CostMax}) r.replace_cost = CostMax;
        else r.replace_cost = 48'(sum - 49'(r.path_max));
        expected_paths = {expected_paths, r};
      end
      default: ;
    endcase
  endfunction

  // Driver: bursts of items with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic               offer;
    tpmq_pkg::in_item_t nxt;
    offer = 1'b0;
    nxt = in_item;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold current item
    end else begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        offer = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        end else begin
          burst_left = burst_left - 1;
        end
      end
      start <= offer;
      in_item <= nxt;
    end
  end

  // Monitor: predict on accept, check on strobe
  always @(posedge clk) begin
    tpmq_pkg::out_item_t want;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (start && !busy) predict_item(in_item);
      if (out_valid) begin
        if (expected_paths.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result: path_max=%h cost=%h",
                     out_item.path_max, out_item.replace_cost);
        end else begin
          want = expected_paths.pop_front();
          if (want.path_max !== out_item.path_max ||
              want.replace_cost !== out_item.replace_cost) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: path_max exp %h got %h, cost exp %h got %h",
                       want.path_max, out_item.path_max,
                       want.replace_cost, out_item.replace_cost);
          end
        end
      end
      if (cycles > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_item(tpmq_pkg::op_t op, logic [31:0] a, logic [31:0] b,
                                   logic [31:0] w, logic [31:0] d);
    tpmq_pkg::in_item_t it;
    it.operation = op;
    it.node_a = 10'(a);
    it.node_b = 10'(b);
    it.edge_weight = w;
    it.node_depth = 10'(d);
    pending_items = {pending_items, it};
  endfunction

  // Load nodes 1..n as a tree; deep favors long chains
  function automatic void add_tree(int n, bit deep);
    int p;
    for (int i = 1; i <= n; i++) begin
      if (i == 1 || $urandom_range(0, 40) == 0) p = 0;
      else if (deep && $urandom_range(0, 7) != 0) p = i - 1;
      else p = $urandom_range(1, i - 1);
      tree_dep[i] = (p == 0) ? 10'd1 : tree_dep[p] + 10'd1;
      add_item(tpmq_pkg::OP_LOAD, i, p, pick_weight(), 32'(tree_dep[i]));
    end
  endfunction

  // Queries with some noise: ignored ops, reloads, rebuilds
  function automatic void add_queries(int n, int count);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0: add_item(tpmq_pkg::OP_NONE, $urandom(), $urandom(), $urandom(), $urandom());
        1: add_item(tpmq_pkg::OP_LOAD, $urandom_range(1, n), $urandom_range(0, n),
                    $urandom(), $urandom());
        2: add_item(tpmq_pkg::OP_BUILD, $urandom(), $urandom(), $urandom(), $urandom());
        default: add_item(tpmq_pkg::OP_QUERY, $urandom_range(0, n), $urandom_range(0, n),
                          pick_weight(), $urandom());
      endcase
    end
    add_item(tpmq_pkg::OP_QUERY, $urandom_range(0, n), $urandom_range(0, n),
             pick_weight(), 0);
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || start || busy || expected_paths.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(tpmq_pkg::cfg_idx_t idx, logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    if (idx == tpmq_pkg::CFG_NODE_COUNT) cur_count = val[9:0];
    else if (idx == tpmq_pkg::CFG_MST_TOTAL) cur_total = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    for (int i = 0; i < NumNodes; i++) begin
      node_dep[i] = '0;
      for (int j = 0; j < NumLevels; j++) begin
        lift_anc[i][j] = '0;
        lift_max[i][j] = '0;
      end
    end
    cur_count = 10'd1;
    cur_total = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, single root, sentinel and ignored items
    add_item(tpmq_pkg::OP_LOAD, 0, 32'h3FF, 32'hFFFF_FFFF, 32'h3FF);
    add_item(tpmq_pkg::OP_LOAD, 1, 0, 32'hFFFF_FFFF, 1);
    add_item(tpmq_pkg::OP_BUILD, 0, 0, 0, 0);
    add_item(tpmq_pkg::OP_NONE, 32'h3FF, 32'h3FF, 32'hFFFF_FFFF, 32'h3FF);
    add_item(tpmq_pkg::OP_QUERY, 1, 1, 32'd0, 0);
    add_item(tpmq_pkg::OP_QUERY, 1, 0, 32'd0, 0);
    add_item(tpmq_pkg::OP_QUERY, 0, 1, 32'hFFFF_FFFF, 0);
    add_item(tpmq_pkg::OP_QUERY, 0, 0, 32'h8000_0000, 0);
    wait_idle();

    // Largest tree, top of cost range (saturation)
    write_reg(tpmq_pkg::CFG_NODE_COUNT, 48'd1023);
    write_reg(tpmq_pkg::CFG_MST_TOTAL, CostMax);
    add_tree(1023, 1'b1);
    add_item(tpmq_pkg::OP_BUILD, 0, 0, 0, 0);
    add_item(tpmq_pkg::OP_QUERY, 1023, 1, 32'hFFFF_FFFF, 0);
    add_item(tpmq_pkg::OP_QUERY, 1, 1023, 32'd0, 0);
    add_queries(1023, 30);
    wait_idle();

    // Zero count: build does nothing; zero total drives cost to floor
    write_reg(tpmq_pkg::CFG_NODE_COUNT, 48'd0);
    write_reg(tpmq_pkg::CFG_MST_TOTAL, 48'd0);
    add_item(tpmq_pkg::OP_LOAD, 5, 0, 32'h1234, 32'h3FF);
    add_item(tpmq_pkg::OP_BUILD, 0, 0, 0, 0);
    add_queries(1023, 15);
    wait_idle();

    // Small random trees, random totals
    for (int ph = 0; ph < 3; ph++) begin
      n = $urandom_range(2, 40);
      write_reg(tpmq_pkg::CFG_NODE_COUNT, 48'(n));
      write_reg(tpmq_pkg::CFG_MST_TOTAL, {16'($urandom()), 32'($urandom())});
      add_tree(n, ph[0]);
      add_item(tpmq_pkg::OP_BUILD, 0, 0, 0, 0);
      add_queries(n, 10);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
